// ===== hdl/sorted_table_insert_search_assert.svh =====
// -----------------------------------------------------------------------------
// Sorted table assertion macros
// Shared property forms for the sorted table checks.
// -----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_SEARCH_ASSERT_SVH
`define SORTED_TABLE_INSERT_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STS_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("sorted table check failed");

// Next-cycle implication, disabled during reset.
`define STS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("sorted table check failed");

`endif

// ===== hdl/sts_pkg.sv =====
// -----------------------------------------------------------------------------
// Sorted table package
// Depth, derived widths, codes and transaction types of the sorted table.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sts_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  // compare width for cell position against count and the 8-bit read index
  localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 9;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
    logic [7:0]         index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         position;
    logic signed [31:0] entry_value;
    logic [8:0]         entry_count;
  } out_item_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               cap;        // capture compare flags
    logic signed [31:0] cmp_value;
    logic [7:0]         rd_index;
    logic               shift;      // commit an insert
    logic signed [31:0] ins_value;
    logic [CNT_W-1:0]   count;
  } cell_bcast_t;

  // reduced chain flags handed to the controller
  typedef struct packed {
    logic               dup;
    logic               rd_hit;
    logic [IDX_W-1:0]   at_pos;
    logic [IDX_W-1:0]   dup_pos;
    logic signed [31:0] rd_value;
  } enc_t;

endpackage

// ===== hdl/sts_cell.sv =====
// -----------------------------------------------------------------------------
// Sorted table cell
// Holds one entry; compares against the broadcast value and shifts right.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sts_cell import sts_pkg::*; (
  input  logic               clk,
  input  cell_bcast_t        bcast,
  input  logic [CMP_W-1:0]   cell_pos,
  input  logic               left_ge,
  input  logic signed [31:0] left_entry,
  output logic               ge,
  output logic               bnd,
  output logic               eq,
  output logic               sel,
  output logic signed [31:0] entry
);

  logic               occ;
  logic               ge_r;
  logic               eq_r;
  logic               sel_r;
  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;

  assign occ = cell_pos < CMP_W'(bcast.count);

  // empty cells count as larger than anything
  always_ff @(posedge clk) begin
    if (bcast.cap) begin
      ge_r  <= !occ || (entry_r > bcast.cmp_value);
      eq_r  <= occ && (entry_r == bcast.cmp_value);
      sel_r <= occ && (cell_pos == CMP_W'(bcast.rd_index));
    end
  end

  always_comb begin
    if (left_ge) begin
      entry_nxt = left_entry;
    end else if (ge_r) begin
      entry_nxt = bcast.ins_value;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (bcast.shift) begin
      entry_r <= entry_nxt;
    end
  end

  assign ge    = ge_r;
  assign bnd   = ge_r && !left_ge;
  assign eq    = eq_r;
  assign sel   = sel_r;
  assign entry = entry_r;

endmodule

// ===== hdl/sts_encode.sv =====
// -----------------------------------------------------------------------------
// Sorted table flag encoder
// Reduces the per-cell flags to a hit, positions and the read entry.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sts_encode import sts_pkg::*; (
  input  logic [TABLE_DEPTH-1:0] bnd_v,
  input  logic [TABLE_DEPTH-1:0] eq_v,
  input  logic [TABLE_DEPTH-1:0] sel_v,
  input  logic signed [31:0]     entries [TABLE_DEPTH],
  output enc_t                   enc
);

  logic [IDX_W-1:0]   at_acc;
  logic [IDX_W-1:0]   dup_acc;
  logic signed [31:0] rd_acc;

  // flags are one-hot, so an OR of the tagged positions is the encode
  always_comb begin
    at_acc  = '0;
    dup_acc = '0;
    rd_acc  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (bnd_v[i]) begin
        at_acc = at_acc | IDX_W'(i);
      end
      if (eq_v[i]) begin
        dup_acc = dup_acc | IDX_W'(i);
      end
      if (sel_v[i]) begin
        rd_acc = rd_acc | entries[i];
      end
    end
  end

  assign enc.dup      = |eq_v;
  assign enc.rd_hit   = |sel_v;
  assign enc.at_pos   = at_acc;
  assign enc.dup_pos  = dup_acc;
  assign enc.rd_value = rd_acc;

endmodule

// ===== hdl/sorted_table_insert_search.sv =====
// -----------------------------------------------------------------------------
// Sorted table with insert, search, read and clear
// Ascending table of distinct signed 32-bit values in a chain of cells.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_item and raise start; the transaction is taken at
//   a rising edge with start high and busy low. mode selects insert, search,
//   read at index, or clear.
//   Result channel: exactly one result per transaction, shown on out_item for
//   one cycle with out_valid high. The receiver cannot stall; it must take the
//   result in that cycle.
//   Timing: the accepting edge captures the command and the compare flags of
//   all cells against the broadcast value. busy is high in the cycle right
//   after the accept, while the flags are encoded; the edge that ends it
//   registers the result and, on an insert, shifts the larger entries one
//   cell right. No new transaction is taken while busy; the next can be taken
//   on the same edge that takes the previous result.
//   Reset (rst_n low, synchronous) empties the table at once; there is no
//   clearing pass. Entries beyond the count are never read.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_table_insert_search_assert.svh"

module sorted_table_insert_search import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic               accept;
  logic               busy_r;
  in_item_t           cmd_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  out_item_t          out_item_r;
  out_item_t          out_item_nxt;
  logic               full;
  logic               shift_en;
  cell_bcast_t        bcast;
  enc_t               enc;

  logic [TABLE_DEPTH-1:0] ge_v;
  logic [TABLE_DEPTH-1:0] bnd_v;
  logic [TABLE_DEPTH-1:0] eq_v;
  logic [TABLE_DEPTH-1:0] sel_v;
  logic signed [31:0]     entries [TABLE_DEPTH];

  assign accept = start && !busy_r;
  assign full   = count_r == CNT_W'(TABLE_DEPTH);

  // insert commits only when the value is new and there is room
  assign shift_en = busy_r && (cmd_r.mode == MODE_INSERT) && !enc.dup && !full;

  // compare uses the incoming value; the shift uses the held command
  assign bcast.cap       = accept;
  assign bcast.cmp_value = in_item.value;
  assign bcast.rd_index  = in_item.index;
  assign bcast.shift     = shift_en;
  assign bcast.ins_value = cmd_r.value;
  assign bcast.count     = count_r;

  // ---------------------------------------------------------------------------
  // Cell chain: cell i holds entry i; at the insert point it takes the new value, past it from cell i-1, on a shift
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    logic               l_ge;
    logic signed [31:0] l_entry;
    if (gi == 0) begin : g_head
      assign l_ge    = 1'b0;
      assign l_entry = '0;
    end else begin : g_link
      assign l_ge    = ge_v[gi-1];
      assign l_entry = entries[gi-1];
    end
    sts_cell u_cell (
      .clk        (clk),
      .bcast      (bcast),
      .cell_pos   (CMP_W'(gi)),
      .left_ge    (l_ge),
      .left_entry (l_entry),
      .ge         (ge_v[gi]),
      .bnd        (bnd_v[gi]),
      .eq         (eq_v[gi]),
      .sel        (sel_v[gi]),
      .entry      (entries[gi])
    );
  end

  sts_encode u_encode (
    .bnd_v   (bnd_v),
    .eq_v    (eq_v),
    .sel_v   (sel_v),
    .entries (entries),
    .enc     (enc)
  );

  // ---------------------------------------------------------------------------
  // Result formation in the busy cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    count_nxt                = count_r;
    out_item_nxt.status      = ST_OK;
    out_item_nxt.position    = '0;
    out_item_nxt.entry_value = cmd_r.value;
    case (cmd_r.mode)
      MODE_INSERT: begin
        if (enc.dup) begin
          out_item_nxt.status   = ST_DUPLICATE;
          out_item_nxt.position = 8'(enc.dup_pos);
        end else if (full) begin
          out_item_nxt.status   = ST_FULL;
        end else begin
          out_item_nxt.position = 8'(enc.at_pos);
          count_nxt             = count_r + CNT_W'(1);
        end
      end
      MODE_SEARCH: begin
        if (enc.dup) begin
          out_item_nxt.position = 8'(enc.dup_pos);
        end else begin
          out_item_nxt.status   = ST_NOT_FOUND;
        end
      end
      MODE_READ: begin
        out_item_nxt.position = cmd_r.index;
        if (enc.rd_hit) begin
          out_item_nxt.entry_value = enc.rd_value;
        end else begin
          out_item_nxt.status      = ST_BAD_INDEX;
          out_item_nxt.entry_value = '0;
        end
      end
      MODE_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    out_item_nxt.entry_count = 9'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (busy_r) begin
        count_r <= count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item;
    end
    if (busy_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `STS_ASSERT_NEXT(a_result_follows, clk, rst_n, busy_r, out_valid_r)
  `STS_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(TABLE_DEPTH))
  `STS_ASSERT_NEXT(a_insert_grows, clk, rst_n, shift_en, count_r == $past(count_r) + CNT_W'(1))
  `STS_ASSERT_IMPLY(a_flags_onehot, clk, rst_n, busy_r, $onehot0(eq_v) && $onehot0(bnd_v))

endmodule

// ===== sim/sorted_table_insert_search_test.sv =====
// -----------------------------------------------------------------------------
// Sorted table testbench
// A directed table, then random command episodes, against a shadow sorted table.
// The episodes include runs that fill the table to its depth.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_insert_search_test;
  import sts_pkg::*;

  localparam int N_DIR       = 23;
  localparam int N_RANDOM    = 1650;
  localparam int N_TOTAL     = N_DIR + N_RANDOM;
  localparam int LAST_QUIET  = 150;     // final transactions sent with no idle_cycles gaps
  localparam int DRAIN_TAIL  = 4;       // cycles after the last result
  localparam int CYCLE_LIMIT = 100000;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  sorted_table_insert_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the table, updated as each transaction is accepted
  logic signed [31:0] shadow_entries [TABLE_DEPTH];
  int                 shadow_count;

  out_item_t expected_results [$];
  int        err_count;
  int        items_sent;
  int        results_seen;
  int        status_seen [5];
  int        full_hits;
  int        cycle_count;

  typedef struct {
    in_item_t  item;
    bit        typed;   // want is written into the table
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR];

  // ---------------------------------------------------------------------------
  // Shadow table: ascending, distinct entries. The first position whose entry is
  // not below the value is both the insert point and the match point.
  // ---------------------------------------------------------------------------
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int        at;
    bit        hit;
    at  = 0;
    while (at < shadow_count && shadow_entries[at] < it.value) at++;
    hit = (at < shadow_count) && (shadow_entries[at] == it.value);
    r.status      = ST_OK;
    r.position    = '0;
    r.entry_value = it.value;
    case (mode_t'(it.mode))
      MODE_INSERT: begin
        if (hit) begin
          // a present value is rejected even when the table is full
          r.status   = ST_DUPLICATE;
          r.position = 8'(at);
        end else if (shadow_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int j = shadow_count; j > at; j--) shadow_entries[j] = shadow_entries[j-1];
          shadow_entries[at] = it.value;
          shadow_count++;
          r.position = 8'(at);
        end
      end
      MODE_SEARCH: begin
        if (hit) r.position = 8'(at);
        else     r.status   = ST_NOT_FOUND;
      end
      MODE_READ: begin
        r.position = it.index;
        if (int'(it.index) < shadow_count) begin
          r.entry_value = shadow_entries[it.index];
        end else begin
          r.status      = ST_BAD_INDEX;
          r.entry_value = '0;
        end
      end
      default: begin
        shadow_count = 0;
      end
    endcase
    r.entry_count = 9'(shadow_count);
    return r;
  endfunction

  function automatic in_item_t cmd(mode_t m, logic signed [31:0] v, logic [7:0] idx);
    in_item_t it;
    it.mode  = m;
    it.value = v;
    it.index = idx;
    return it;
  endfunction

  function automatic out_item_t res(status_t s, logic [7:0] pos, logic signed [31:0] ev,
                                    logic [8:0] cnt);
    out_item_t r;
    r.status      = s;
    r.position    = pos;
    r.entry_value = ev;
    r.entry_count = cnt;
    return r;
  endfunction

  // values: wide random, a narrow band around zero, extremes, or a present entry
  function automatic logic signed [31:0] pick_value(bit fresh);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (fresh && sel < 9) return $urandom;
    if (sel >= 7 && shadow_count > 0) return shadow_entries[$urandom_range(0, shadow_count - 1)];
    case (sel)
      4, 5: return $urandom_range(0, 31) - 16;
      6: begin
        case ($urandom_range(0, 5))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return VAL_MIN + 1;
          3: return VAL_MAX - 1;
          4: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_cmd(int w_ins, int w_srch, int w_rd, int w_clr, bit fresh);
    in_item_t    it;
    int unsigned r;
    r        = $urandom_range(0, w_ins + w_srch + w_rd + w_clr - 1);
    it.value = $urandom;
    it.index = 8'($urandom_range(0, 255));
    if (r < w_ins) begin
      it.mode  = MODE_INSERT;
      it.value = pick_value(fresh);
    end else if (r < w_ins + w_srch) begin
      it.mode  = MODE_SEARCH;
      it.value = pick_value(1'b0);
    end else if (r < w_ins + w_srch + w_rd) begin
      it.mode = MODE_READ;
      // mostly valid positions; the rest are random and may fall past the count
      if (shadow_count > 0 && $urandom_range(0, 4) != 0)
        it.index = 8'($urandom_range(0, shadow_count - 1));
    end else begin
      it.mode = MODE_CLEAR;
    end
    return it;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.mode  = 2'($urandom_range(0, 3));
    it.value = $urandom;
    it.index = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge that took the
  // transaction, start still high so the next one can follow at once.
  // ---------------------------------------------------------------------------
  task automatic issue(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_result(it);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // start low with junk on the data lines, which must be ignored
  task automatic idle_cycles(int n);
    for (int i = 0; i < n; i++) begin
      start   <= 1'b0;
      in_item <= noise_item();
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobed result against the oldest expectation
  // ---------------------------------------------------------------------------
  out_item_t want_now;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      results_seen++;
      if (out_item.status < 5) status_seen[out_item.status]++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: %p", out_item));
      end else begin
        want_now = expected_results.pop_front();
        if (out_item.status !== want_now.status)
          report_mismatch($sformatf("status got %0d want %0d (result %0d)",
                                    out_item.status, want_now.status, results_seen));
        if (out_item.position !== want_now.position)
          report_mismatch($sformatf("position got %0d want %0d (result %0d)",
                                    out_item.position, want_now.position, results_seen));
        if (out_item.entry_value !== want_now.entry_value)
          report_mismatch($sformatf("entry_value got %0h want %0h (result %0d)",
                                    out_item.entry_value, want_now.entry_value, results_seen));
        if (out_item.entry_count !== want_now.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d (result %0d)",
                                    out_item.entry_count, want_now.entry_count, results_seen));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int  ep;
    int  ep_len;
    bit  filling;
    bit  idle_on;
    in_item_t it;

    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    err_count    = 0;
    items_sent   = 0;
    results_seen = 0;
    full_hits    = 0;
    cycle_count  = 0;
    shadow_count = 0;
    ep           = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // empty table, extremes at both ends, duplicates, misses, bad reads, clear
    dir_rows = '{
      '{cmd(MODE_READ,   32'sd0,     8'd0),   1'b1, res(ST_BAD_INDEX, 8'd0,   32'sd0,  9'd0)},
      '{cmd(MODE_SEARCH, 32'sd0,     8'd0),   1'b1, res(ST_NOT_FOUND, 8'd0,   32'sd0,  9'd0)},
      '{cmd(MODE_INSERT, VAL_MAX,    8'd0),   1'b1, res(ST_OK,        8'd0,   VAL_MAX, 9'd1)},
      '{cmd(MODE_INSERT, VAL_MIN,    8'd255), 1'b1, res(ST_OK,        8'd0,   VAL_MIN, 9'd2)},
      '{cmd(MODE_INSERT, 32'sd0,     8'd0),   1'b1, res(ST_OK,        8'd1,   32'sd0,  9'd3)},
      '{cmd(MODE_INSERT, 32'sd0,     8'd0),   1'b1, res(ST_DUPLICATE, 8'd1,   32'sd0,  9'd3)},
      '{cmd(MODE_INSERT, VAL_MAX,    8'd0),   1'b1, res(ST_DUPLICATE, 8'd2,   VAL_MAX, 9'd3)},
      '{cmd(MODE_SEARCH, VAL_MIN,    8'd0),   1'b1, res(ST_OK,        8'd0,   VAL_MIN, 9'd3)},
      '{cmd(MODE_SEARCH, VAL_MAX,    8'd0),   1'b1, res(ST_OK,        8'd2,   VAL_MAX, 9'd3)},
      '{cmd(MODE_SEARCH, 32'sd1,     8'd0),   1'b1, res(ST_NOT_FOUND, 8'd0,   32'sd1,  9'd3)},
      '{cmd(MODE_READ,   32'sd0,     8'd2),   1'b1, res(ST_OK,        8'd2,   VAL_MAX, 9'd3)},
      '{cmd(MODE_READ,   32'sd0,     8'd3),   1'b1, res(ST_BAD_INDEX, 8'd3,   32'sd0,  9'd3)},
      '{cmd(MODE_READ,   VAL_MAX,    8'd255), 1'b1, res(ST_BAD_INDEX, 8'd255, 32'sd0,  9'd3)},
      '{cmd(MODE_INSERT, -32'sd1,    8'd0),   1'b1, res(ST_OK,        8'd1,   -32'sd1, 9'd4)},
      '{cmd(MODE_INSERT, VAL_MIN+1,  8'd0),   1'b0, '0},
      '{cmd(MODE_INSERT, VAL_MAX-1,  8'd0),   1'b0, '0},
      '{cmd(MODE_READ,   32'shdeadbeef, 8'd0), 1'b0, '0},
      '{cmd(MODE_SEARCH, -32'sd1,    8'd7),   1'b0, '0},
      '{cmd(MODE_CLEAR,  32'sh12345678, 8'd9), 1'b1, res(ST_OK,     8'd0, 32'sh12345678, 9'd0)},
      '{cmd(MODE_READ,   32'sd0,     8'd0),   1'b1, res(ST_BAD_INDEX, 8'd0,   32'sd0,  9'd0)},
      '{cmd(MODE_SEARCH, VAL_MAX,    8'd0),   1'b1, res(ST_NOT_FOUND, 8'd0,   VAL_MAX, 9'd0)},
      '{cmd(MODE_INSERT, 32'sd5,     8'd255), 1'b1, res(ST_OK,        8'd0,   32'sd5,  9'd1)},
      '{cmd(MODE_CLEAR,  VAL_MIN,    8'd255), 1'b1, res(ST_OK,        8'd0,   VAL_MIN, 9'd0)}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      issue(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 4));
    end

    // let the directed part settle completely before the random episodes
    drain_results();

    // Random episodes. Every fourth one, the first included, clears and then
    // pushes mostly fresh inserts until the table is full and rejecting.
    while (items_sent < N_TOTAL) begin
      ep++;
      filling = (ep % 4 == 1);
      idle_on = $urandom_range(0, 1);
      ep_len  = filling ? 330 : $urandom_range(20, 120);
      if ($urandom_range(0, 3) == 0) drain_results();
      if (filling || $urandom_range(0, 1) == 1)
        issue(cmd(MODE_CLEAR, $urandom, 8'($urandom_range(0, 255))), 1'b0, '0);
      for (int k = 0; k < ep_len && items_sent < N_TOTAL; k++) begin
        it = filling ? make_cmd(90, 4, 6, 0, 1'b1) : make_cmd(45, 25, 25, 3, 1'b0);
        if (it.mode == MODE_INSERT && shadow_count >= TABLE_DEPTH) full_hits++;
        issue(it, 1'b0, '0);
        if (idle_on && items_sent < N_TOTAL - LAST_QUIET && $urandom_range(0, 3) == 0)
          idle_cycles($urandom_range(1, 4));
      end
    end

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Ran %0d transactions in %0d episodes, %0d results; inserts on a full table: %0d",
             items_sent, ep, results_seen, full_hits);
    $display("Status mix: ok %0d, not found %0d, duplicate %0d, full %0d, bad index %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sts_pkg.sv
hdl/sts_cell.sv
hdl/sts_encode.sv
hdl/sorted_table_insert_search.sv
sim/sorted_table_insert_search_test.sv
